// ===== rtl/core/dvw_pkg.sv =====
// dvw_pkg: shared constants, register indexes and rom builders for depth_vertex_to_world
// used by rtl/core/depth_vertex_to_world.sv, no dependencies
package dvw_pkg;

    localparam int POW_TABLE_BITS_DEF = 8;
    localparam int POW_TABLE_BITS_MAX = 12;
    localparam int LOG_W = 16;
    localparam int EXP_W = 17;

    localparam logic [2:0] REG_DEPTH_NEAR   = 3'd0;
    localparam logic [2:0] REG_DEPTH_FAR    = 3'd1;
    localparam logic [2:0] REG_STRETCH_EXP  = 3'd2;
    localparam logic [2:0] REG_OUT_X_COEFFS = 3'd3;
    localparam logic [2:0] REG_OUT_Y_COEFFS = 3'd4;
    localparam logic [2:0] REG_OUT_Z_COEFFS = 3'd5;

    localparam logic [15:0] RST_DEPTH_NEAR   = 16'd0;
    localparam logic [15:0] RST_DEPTH_FAR    = 16'd16384;
    localparam logic [15:0] RST_STRETCH_EXP  = 16'd4096;
    localparam logic [47:0] RST_OUT_X_COEFFS = 48'd16384;
    localparam logic [47:0] RST_OUT_Y_COEFFS = 48'd16384 << 16;
    localparam logic [47:0] RST_OUT_Z_COEFFS = 48'd16384 << 32;

    localparam logic [16:0] T_ONE = 17'd65536;
    localparam logic [15:0] RAW_OFFSET = 16'd256;

    typedef logic [LOG_W*(2**POW_TABLE_BITS_MAX)-1:0] t_log_rom;
    typedef logic [EXP_W*(2**POW_TABLE_BITS_MAX)-1:0] t_exp_rom;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v = v_in;
        res = 64'd0;
        bitv = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (bitv > v) bitv = bitv >> 2;
        end
        for (int s = 0; s < 32; s++) begin
            if (bitv != 64'd0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // floor(log2(1 + i/2^b)) in q0.16 by repeated squaring
    function automatic t_log_rom log_rom_build(input int b);
        t_log_rom rom;
        logic [63:0] x;
        logic [15:0] l;
        rom = '0;
        for (int i = 0; i < 2**b; i++) begin
            x = (64'd1 << b) + 64'(i);
            x = x << (30 - b);
            l = 16'd0;
            for (int s = 0; s < 16; s++) begin
                x = (x * x) >> 30;
                l = l << 1;
                if (x >= (64'd1 << 31)) begin
                    l = l | 16'd1;
                    x = x >> 1;
                end
            end
            rom[i*LOG_W +: LOG_W] = l;
        end
        return rom;
    endfunction

    // 2^(-j/2^b) in q1.16 from products of 2^(-2^-m)
    function automatic t_exp_rom exp_rom_build(input int b);
        t_exp_rom rom;
        logic [63:0] c;
        logic [63:0] acc;
        rom = '0;
        for (int j = 0; j < 2**b; j++) begin
            c = isqrt64(64'd1 << 61);
            acc = 64'd1 << 31;
            for (int m = 1; m <= b; m++) begin
                if (((j >> (b - m)) & 1) != 0) acc = (acc * c) >> 31;
                c = isqrt64(c << 31);
            end
            rom[j*EXP_W +: EXP_W] = EXP_W'(acc >> 15);
        end
        return rom;
    endfunction

endpackage

// ===== rtl/core/depth_vertex_to_world.sv =====
// depth_vertex_to_world: depth vertex to rotated world point, fully pipelined
// depends on rtl/core/dvw_pkg.sv
//
//  channel   dir  signals                               payload
//  s         in   i_s_tvalid o_s_tready i_s_tdata[47:0]  screen_x, depth_raw, screen_z
//  m         out  o_m_tvalid i_m_tready o_m_tdata[71:0]  world_x, world_y, world_z
//  cfg       in   i_cfg_we i_cfg_addr i_cfg_wdata[47:0]  register writes
//
// one vertex per cycle while the output is not stalled; one decode stage, sixteen stages of the
// one-bit-per-stage depth divider, four power stages, then y, products and sum/round
// all stages move together; a result waiting at the output stalls the whole pipe
// and holds every stage, so no transfer is lost or repeated
// reset clears valid bits and loads the register defaults (diagonal matrix, one half on the diagonal)
module depth_vertex_to_world #(
    parameter int POW_TABLE_BITS = dvw_pkg::POW_TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // screen_x[15:0], depth_raw[31:16], screen_z[47:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // world_x[23:0], world_y[47:24], world_z[71:48]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [47:0] i_cfg_wdata
);

    localparam int B = POW_TABLE_BITS;
    localparam int NDIV = 16;
    localparam int NX = 22;
    localparam int NST = 24;
    localparam dvw_pkg::t_log_rom LOG_ROM = dvw_pkg::log_rom_build(B);
    localparam dvw_pkg::t_exp_rom EXP_ROM = dvw_pkg::exp_rom_build(B);

    logic [15:0] r_near, r_far, r_exp;
    logic [47:0] r_cx, r_cy, r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= dvw_pkg::RST_DEPTH_NEAR;
            r_far  <= dvw_pkg::RST_DEPTH_FAR;
            r_exp  <= dvw_pkg::RST_STRETCH_EXP;
            r_cx   <= dvw_pkg::RST_OUT_X_COEFFS;
            r_cy   <= dvw_pkg::RST_OUT_Y_COEFFS;
            r_cz   <= dvw_pkg::RST_OUT_Z_COEFFS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dvw_pkg::REG_DEPTH_NEAR:   r_near <= i_cfg_wdata[15:0];
                dvw_pkg::REG_DEPTH_FAR:    r_far  <= i_cfg_wdata[15:0];
                dvw_pkg::REG_STRETCH_EXP:  r_exp  <= i_cfg_wdata[15:0];
                dvw_pkg::REG_OUT_X_COEFFS: r_cx   <= i_cfg_wdata;
                dvw_pkg::REG_OUT_Y_COEFFS: r_cy   <= i_cfg_wdata;
                dvw_pkg::REG_OUT_Z_COEFFS: r_cz   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [NST-1:0] r_v;
    logic en;
    assign en = !r_v[NST-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[NST-2:0], i_s_tvalid};
    end

    // decode: numerator, denominator and the cases that need no division
    logic signed [18:0] s_d, s_num, s_den, s_an, s_dn;
    logic        n_spc;
    logic [16:0] n_tsp;
    logic [15:0] n_rem0, n_den0;

    always_comb begin
        s_d   = $signed({3'b0, i_s_tdata[31:16]}) - $signed({3'b0, dvw_pkg::RAW_OFFSET});
        s_num = $signed({3'b0, r_far}) - s_d;
        s_den = $signed({3'b0, r_far}) - $signed({3'b0, r_near});
        s_an  = (s_den < 0) ? -s_num : s_num;
        s_dn  = (s_den < 0) ? -s_den : s_den;
        n_spc  = 1'b1;
        n_tsp  = 17'd0;
        n_rem0 = 16'd0;
        n_den0 = 16'd1;
        if (s_den == 0) begin
            n_tsp = (s_d <= $signed({3'b0, r_far})) ? dvw_pkg::T_ONE : 17'd0;
        end else if (s_an <= 0) begin
            n_tsp = 17'd0;
        end else if (s_an >= s_dn) begin
            n_tsp = dvw_pkg::T_ONE;
        end else begin
            n_spc  = 1'b0;
            n_rem0 = s_an[15:0];
            n_den0 = s_dn[15:0];
        end
    end

    logic [15:0] r_rem [NDIV+1];
    logic [15:0] r_dd  [NDIV+1];
    logic [15:0] r_q   [NDIV+1];
    logic        r_spc [NDIV+1];
    logic [16:0] r_tsp [NDIV+1];
    logic [15:0] r_x   [NX];
    logic [15:0] r_z   [NX];

    logic [15:0] n_rem [NDIV+1];
    logic        n_qb  [NDIV+1];

    // one quotient bit per stage
    always_comb begin
        logic [16:0] r2;
        n_rem[0] = 16'd0;
        n_qb[0]  = 1'b0;
        for (int k = 1; k <= NDIV; k++) begin
            r2 = {r_rem[k-1], 1'b0};
            if (r2 >= {1'b0, r_dd[k-1]}) begin
                n_rem[k] = 16'(r2 - {1'b0, r_dd[k-1]});
                n_qb[k]  = 1'b1;
            end else begin
                n_rem[k] = r2[15:0];
                n_qb[k]  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= n_rem0;
            r_dd[0]  <= n_den0;
            r_q[0]   <= 16'd0;
            r_spc[0] <= n_spc;
            r_tsp[0] <= n_tsp;
            r_x[0]   <= i_s_tdata[15:0];
            r_z[0]   <= i_s_tdata[47:32];
            for (int k = 1; k <= NDIV; k++) begin
                r_rem[k] <= n_rem[k];
                r_dd[k]  <= r_dd[k-1];
                r_q[k]   <= {r_q[k-1][14:0], n_qb[k]};
                r_spc[k] <= r_spc[k-1];
                r_tsp[k] <= r_tsp[k-1];
            end
            for (int k = 1; k < NX; k++) begin
                r_x[k] <= r_x[k-1];
                r_z[k] <= r_z[k-1];
            end
        end
    end

    // power: leading one and log index
    logic [16:0]  s_t;
    logic [4:0]   s_pos;
    logic [4:0]   s_shift;
    logic [31:0]  s_fw;
    logic         n_psp;
    logic [16:0]  n_pval;

    always_comb begin
        s_t   = r_spc[NDIV] ? r_tsp[NDIV] : {1'b0, r_q[NDIV]};
        s_pos = 5'd0;
        for (int b = 0; b < 16; b++) begin
            if (s_t[b]) s_pos = 5'(b);
        end
        s_shift = 5'd16 - s_pos;
        s_fw    = {16'd0, s_t[15:0]} << s_shift;
        n_psp   = 1'b1;
        n_pval  = dvw_pkg::T_ONE;
        if (s_t == 17'd0) n_pval = (r_exp == 16'd0) ? dvw_pkg::T_ONE : 17'd0;
        else if (!s_t[16]) n_psp = 1'b0;
    end

    logic         r_psp1, r_psp2, r_psp3;
    logic [16:0]  r_pval1, r_pval2, r_pval3;
    logic [4:0]   r_shift;
    logic [B-1:0] r_idx;
    logic [20:0]  r_nl;
    logic [24:0]  r_p;
    logic [16:0]  r_pw;
    logic signed [15:0] r_y;

    logic [15:0]  s_l;
    logic [36:0]  s_pm;
    logic [15:0]  s_g;
    logic [B-1:0] s_j;
    logic [16:0]  s_er;
    logic [16:0]  s_pw;
    logic [24:0]  s_y200;

    always_comb begin
        s_l  = LOG_ROM[int'(r_idx)*dvw_pkg::LOG_W +: dvw_pkg::LOG_W];
        s_pm = 37'(r_nl) * 37'(r_exp);
        s_g  = r_p[15:0];
        s_j  = s_g[15 -: B];
        s_er = EXP_ROM[int'(s_j)*dvw_pkg::EXP_W +: dvw_pkg::EXP_W];
        if (r_psp3) s_pw = r_pval3;
        else if (r_p[24:16] > 9'd16) s_pw = 17'd0;
        else s_pw = s_er >> r_p[20:16];
        s_y200 = 25'(r_pw) * 25'd200;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_psp1  <= n_psp;
            r_pval1 <= n_pval;
            r_shift <= s_shift;
            r_idx   <= s_fw[15 -: B];
            r_psp2  <= r_psp1;
            r_pval2 <= r_pval1;
            r_nl    <= {r_shift, 16'd0} - {5'd0, s_l};
            r_psp3  <= r_psp2;
            r_pval3 <= r_pval2;
            r_p     <= s_pm[36:12];
            r_pw    <= s_pw;
            r_y     <= -$signed({1'b0, s_y200[23:9]});
        end
    end

    // rotation: nine products, then sum, round and sign-extend to 24 bits
    logic signed [31:0] r_pr [9];
    logic signed [15:0] s_vec [3];
    logic [47:0]        s_cf  [3];

    always_comb begin
        s_vec[0] = $signed(r_x[NX-1]);
        s_vec[1] = r_y;
        s_vec[2] = $signed(r_z[NX-1]);
        s_cf[0]  = r_cx;
        s_cf[1]  = r_cy;
        s_cf[2]  = r_cz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pr[r*3+c] <= $signed(s_cf[r][c*16 +: 16]) * s_vec[c];
                end
            end
        end
    end

    logic signed [33:0] s_sum [3];
    logic signed [18:0] s_rnd [3];
    logic [23:0]        s_sat [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s_sum[r] = 34'(r_pr[r*3]) + 34'(r_pr[r*3+1]) + 34'(r_pr[r*3+2]) + 34'sd16384;
            s_rnd[r] = 19'(s_sum[r] >>> 15);
            // cannot overflow 24 bits with 16-bit operands
            s_sat[r] = 24'(s_rnd[r]);
        end
    end

    logic [71:0] r_out;
    always_ff @(posedge i_clk) begin
        if (en) r_out <= {s_sat[2], s_sat[1], s_sat[0]};
    end
    assign o_m_tdata = r_out;

endmodule
